// ===== hw/rtl/efd_pkg.sv =====
// Shared constants and types for the escaped frame deframer.
package efd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;

    localparam logic [7:0] ESCAPE_RESET = 8'h48;
    localparam logic [7:0] START_RESET  = 8'h10;

    // configuration register indexes
    localparam logic CFG_ESCAPE = 1'b0;
    localparam logic CFG_START  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_PAYLOAD  = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic drain_start;
    } t_buf_ctl;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_buf_item;

endpackage

// ===== hw/rtl/efd_frame_buf.sv =====
// Frame payload memory with its drain sequencer.
module efd_frame_buf
    import efd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int ADDR_W          = 6,
    parameter int LEN_W           = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_buf_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [LEN_W-1:0]  i_drain_len,
    input  logic              i_out_free,
    output t_buf_item         o_item,
    output logic              o_busy
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_READ = 2'd1;
    localparam logic [1:0] D_HOLD = 2'd2;

    logic [7:0]       r_mem [0:MAX_FRAME_BYTES-1];
    logic [7:0]       r_rd_data;
    logic [1:0]       r_dstate, n_dstate;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_len;
    logic             w_last;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_dstate == D_READ) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
        if (i_ctl.drain_start) begin
            r_len <= i_drain_len;
        end
    end

    assign w_last = ((r_idx + LEN_W'(1)) == r_len);

    always_comb begin
        n_dstate = r_dstate;
        n_idx    = r_idx;
        case (r_dstate)
            D_IDLE: begin
                if (i_ctl.drain_start) begin
                    n_dstate = D_READ;
                    n_idx    = '0;
                end
            end
            D_READ: begin
                n_dstate = D_HOLD;
            end
            D_HOLD: begin
                if (i_out_free) begin
                    n_idx    = r_idx + LEN_W'(1);
                    n_dstate = w_last ? D_IDLE : D_READ;
                end
            end
            default: begin
                n_dstate = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= D_IDLE;
            r_idx    <= '0;
        end else begin
            r_dstate <= n_dstate;
            r_idx    <= n_idx;
        end
    end

    assign o_item.valid = (r_dstate == D_HOLD);
    assign o_item.last  = w_last;
    assign o_item.data  = r_rd_data;
    assign o_busy       = (r_dstate != D_IDLE);

endmodule

// ===== hw/rtl/escaped_frame_deframer.sv =====
// Top level: escape-framed byte stream deframer.
// Timing: a byte is parsed in the cycle it is accepted; an empty-frame or overflow
//   result is shown in the next cycle, and the first payload byte of a closed frame
//   passes the drain state register, the registered memory read and the output register.
// Throughput: one byte per cycle while parsing and the output is not stalled; each drained
//   payload byte is read, then held, through the frame memory's single registered read port.
// Reset: synchronous, active low; clears mode, length, drain and output valid.
//   Registers return to escape 0x48 and start 0x10; the frame memory is not cleared.
module escaped_frame_deframer
    import efd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic       o_m_axis_tlast,
    output logic [1:0] o_m_axis_tuser,   // [1:0] status
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_data
);

    localparam int ADDR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_FRAME_BYTES);

    localparam logic [1:0] M_HUNT    = 2'd0;
    localparam logic [1:0] M_EXPECT  = 2'd1;
    localparam logic [1:0] M_COLLECT = 2'd2;
    localparam logic [1:0] M_ESCAPED = 2'd3;

    logic [7:0]       r_escape, r_start;
    logic [1:0]       r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_last;
    logic [1:0]       r_out_status;

    logic             w_accept, w_out_free, w_busy;
    logic             w_is_esc, w_is_start, w_append;
    logic             w_res_valid;
    logic [1:0]       w_res_status;
    t_buf_ctl         w_ctl;
    t_buf_item        w_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= ESCAPE_RESET;
            r_start  <= START_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_ESCAPE: r_escape <= i_cfg_data;
                CFG_START:  r_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !w_busy && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_is_esc   = (i_s_axis_tdata == r_escape);
    assign w_is_start = (i_s_axis_tdata == r_start);

    always_comb begin
        n_mode           = r_mode;
        n_len            = r_len;
        w_append         = 1'b0;
        w_res_valid      = 1'b0;
        w_res_status     = STAT_PAYLOAD;
        w_ctl.drain_start = 1'b0;
        if (w_accept) begin
            case (r_mode)
                M_HUNT: begin
                    if (w_is_esc) n_mode = M_EXPECT;
                end
                M_EXPECT: begin
                    if (w_is_start) begin
                        n_mode = M_COLLECT;
                        n_len  = '0;
                    end else begin
                        n_mode = M_HUNT;
                    end
                end
                M_COLLECT: begin
                    if (w_is_esc) n_mode = M_ESCAPED;
                    else          w_append = 1'b1;
                end
                M_ESCAPED: begin
                    if (w_is_start) begin
                        // close: empty frame reports itself, otherwise drain the store
                        n_mode = M_HUNT;
                        n_len  = '0;
                        if (r_len == '0) begin
                            w_res_valid  = 1'b1;
                            w_res_status = STAT_EMPTY;
                        end else begin
                            w_ctl.drain_start = 1'b1;
                        end
                    end else if (w_is_esc) begin
                        w_append = 1'b1;
                    end else begin
                        n_mode = M_HUNT;
                        n_len  = '0;
                    end
                end
                default: n_mode = M_HUNT;
            endcase
            if (w_append) begin
                if (r_len == LIMIT) begin
                    n_mode       = M_HUNT;
                    n_len        = '0;
                    w_res_valid  = 1'b1;
                    w_res_status = STAT_OVERFLOW;
                end else begin
                    n_mode = M_COLLECT;
                    n_len  = r_len + LEN_W'(1);
                end
            end
        end
        w_ctl.wr_en = w_append && (r_len != LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_HUNT;
            r_len  <= '0;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
    end

    efd_frame_buf #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .ADDR_W          (ADDR_W),
        .LEN_W           (LEN_W)
    ) u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_addr   (r_len[ADDR_W-1:0]),
        .i_wr_data   (i_s_axis_tdata),
        .i_drain_len (r_len),
        .i_out_free  (w_out_free),
        .o_item      (w_item),
        .o_busy      (w_busy)
    );

    // parse results and drained bytes never compete: input is held off while draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid || w_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (w_res_valid) begin
                r_out_data   <= 8'h00;
                r_out_last   <= 1'b1;
                r_out_status <= w_res_status;
            end else begin
                r_out_data   <= w_item.data;
                r_out_last   <= w_item.last;
                r_out_status <= STAT_PAYLOAD;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== hw/rtl/efd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module efd_checker
    import efd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_s_axis_tready
);

    // a non-payload status is always a lone, zero-data final item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != STAT_PAYLOAD)) |->
            (o_m_axis_tlast && (o_m_axis_tdata == 8'h00)))
        else $error("status item without last or with data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == STAT_PAYLOAD ||
                             o_m_axis_tuser == STAT_EMPTY ||
                             o_m_axis_tuser == STAT_OVERFLOW))
        else $error("unknown status code");

    // no input is taken while a stalled output item is still full
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input ready while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) &&
             $stable(o_m_axis_tuser)))
        else $error("stalled output item changed");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_s_axis_tready (o_s_axis_tready)
);
